@@ hw/rtl/r50p_pkg.sv @@
`default_nettype none

package r50p_pkg;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_IN      = 2'd1,
    PH_BETWEEN = 2'd2,
    PH_DISCARD = 2'd3
  } phase_e;

  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NOARG   = 3'd2;
  localparam logic [2:0] ST_BADCH   = 3'd3;
  localparam logic [2:0] ST_NOCLOSE = 3'd4;

  localparam logic CFG_BIG_ENDIAN = 1'b0;
  localparam logic CFG_SKIP_SPACE = 1'b1;

  localparam logic [15:0] MUL_C0 = 16'd1600;
  localparam logic [15:0] MUL_C1 = 16'd40;

  typedef struct packed {
    logic [1:0]       cnt;
    logic [2:0][7:0]  bytes;
    logic [2:0][2:0]  status;
  } grp_t;

  // bit 6 flags a valid code, bits 5:0 hold the code
  function automatic logic [6:0] code_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c == 8'h20) begin
      r = {1'b1, 6'd0};
    end else if (c == 8'h24) begin
      r = {1'b1, 6'd27};
    end else if (c == 8'h2e) begin
      r = {1'b1, 6'd28};
    end else if (c == 8'h25) begin
      r = {1'b1, 6'd29};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd30)};
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41 + 8'd1)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd1)};
    end
    return r;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/r50p_in_if.sv @@
`default_nettype none

interface r50p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/r50p_out_if.sv @@
`default_nettype none

interface r50p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/r50p_core.sv @@
`default_nettype none

module r50p_core import r50p_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_idx_i,
  input  wire logic   cfg_data_i,
  r50p_in_if.sink     in_i,
  output grp_t        grp_o,
  output logic        grp_vld_o,
  input  wire logic   grp_rdy_i
);

  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       eol_q;
  logic       be_q, skip_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  delim_q, delim_d;
  logic [1:0]  pos_q, pos_d;
  logic [15:0] acc_q, acc_d;
  logic        had_q, had_d;

  logic        fire;
  logic        emit_w, emit_s;
  logic [15:0] w_val, w_sum;
  logic [2:0]  s_val;
  logic [6:0]  code_r;
  logic [15:0] code16;
  grp_t        grp;

  assign fire      = in_vld_q && ((grp.cnt == 2'd0) || grp_rdy_i);
  assign in_i.ready = !in_vld_q || fire;
  assign grp_o     = grp;
  assign grp_vld_o = in_vld_q && (grp.cnt != 2'd0);

  assign code_r = code_of(ch_q);
  assign code16 = 16'(code_r[5:0]);

  always_comb begin
    case (pos_q)
      2'd0:    w_sum = code16 * MUL_C0;
      2'd1:    w_sum = acc_q + code16 * MUL_C1;
      default: w_sum = acc_q + code16;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    delim_d = delim_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    had_d   = had_q;
    emit_w  = 1'b0;
    emit_s  = 1'b0;
    w_val   = acc_q;
    s_val   = ST_DATA;
    if (eol_q) begin
      case (phase_q)
        PH_WAIT: begin
          emit_s = 1'b1;
          s_val  = ST_NOARG;
        end
        PH_IN: begin
          emit_s = 1'b1;
          s_val  = ST_NOCLOSE;
        end
        PH_BETWEEN: begin
          emit_w = (pos_q != 2'd0);
          emit_s = 1'b1;
          s_val  = ST_DONE;
        end
        default: ;
      endcase
      phase_d = PH_WAIT;
      had_d   = 1'b0;
      pos_d   = 2'd0;
      acc_d   = 16'd0;
    end else begin
      case (phase_q)
        PH_WAIT: begin
          delim_d = ch_q;
          had_d   = 1'b0;
          phase_d = PH_IN;
        end
        PH_BETWEEN: begin
          if (!(is_white(ch_q) && skip_q)) begin
            delim_d = ch_q;
            had_d   = 1'b0;
            phase_d = PH_IN;
          end
        end
        PH_IN: begin
          if (ch_q == delim_q) begin
            emit_w  = !had_q && (pos_q == 2'd0);
            w_val   = 16'd0;
            phase_d = PH_BETWEEN;
          end else if (!code_r[6]) begin
            emit_s  = 1'b1;
            s_val   = ST_BADCH;
            pos_d   = 2'd0;
            acc_d   = 16'd0;
            phase_d = PH_DISCARD;
          end else begin
            had_d = 1'b1;
            if (pos_q == 2'd2) begin
              emit_w = 1'b1;
              w_val  = w_sum;
              pos_d  = 2'd0;
              acc_d  = 16'd0;
            end else begin
              pos_d = pos_q + 2'd1;
              acc_d = w_sum;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    grp = '0;
    if (emit_w) begin
      grp.bytes[0] = be_q ? w_val[15:8] : w_val[7:0];
      grp.bytes[1] = be_q ? w_val[7:0] : w_val[15:8];
    end
    if (emit_s) begin
      grp.status[emit_w ? 2'd2 : 2'd0] = s_val;
    end
    grp.cnt = (emit_w ? 2'd2 : 2'd0) + (emit_s ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      be_q     <= 1'b0;
      skip_q   <= 1'b1;
      phase_q  <= PH_WAIT;
      delim_q  <= 8'd0;
      pos_q    <= 2'd0;
      acc_q    <= 16'd0;
      had_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BIG_ENDIAN: be_q   <= cfg_data_i;
          CFG_SKIP_SPACE: skip_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (fire) begin
        phase_q <= phase_d;
        delim_q <= delim_d;
        pos_q   <= pos_d;
        acc_q   <= acc_d;
        had_q   <= had_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q  <= in_i.ch;
      eol_q <= in_i.line_end;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/r50p_serializer.sv @@
`default_nettype none

module r50p_serializer import r50p_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire grp_t  grp_i,
  input  wire logic  grp_vld_i,
  output logic       grp_rdy_o,
  r50p_out_if.source out_o
);

  logic       busy_q;
  logic [1:0] idx_q;
  grp_t       grp_q;
  logic       xfer, is_last;

  assign is_last   = (idx_q == (grp_q.cnt - 2'd1));
  assign xfer      = out_o.valid && out_o.ready;
  assign grp_rdy_o = !busy_q || (xfer && is_last);

  assign out_o.valid    = busy_q;
  assign out_o.out_byte = grp_q.bytes[idx_q];
  assign out_o.status   = grp_q.status[idx_q];
  assign out_o.last     = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (grp_vld_i && grp_rdy_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (xfer) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_vld_i && grp_rdy_o) begin
      grp_q <= grp_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/radix50_text_packer.sv @@
// channel   dir  fields                          transfer when
// in_i      in   ch[7:0], line_end               in_i.valid && in_i.ready
// out_o     out  out_byte[7:0], status[2:0], last out_o.valid && out_o.ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i cfg_we_i high
//
// An item is registered, decoded combinationally into a group of zero to
// three results, and the output stage hands those out one per cycle while
// out_o.ready is high. Items with at most one result flow at one per cycle;
// an item with two or three results holds the output stage until all leave.
// Items pass the input register, then the serializer's group register.
// Reset clears the decode state and resets the config registers at once.
// A stalled output holds its result and backs up the input register.
`default_nettype none

module radix50_text_packer import r50p_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_idx_i,
  input  wire logic  cfg_data_i,
  r50p_in_if.sink    in_i,
  r50p_out_if.source out_o
);

  grp_t grp;
  logic grp_vld, grp_rdy;

  r50p_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .grp_o      (grp),
    .grp_vld_o  (grp_vld),
    .grp_rdy_i  (grp_rdy)
  );

  r50p_serializer u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .grp_i     (grp),
    .grp_vld_i (grp_vld),
    .grp_rdy_o (grp_rdy),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/r50p_checker.sv @@
`default_nettype none

module r50p_checker import r50p_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic [2:0] status_i,
  input wire logic       last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(status_i)
      && $stable(last_i))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_DATA || status_i == ST_DONE || status_i == ST_NOARG
      || status_i == ST_BADCH || status_i == ST_NOCLOSE))
    else $error("status out of range");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_DATA |-> out_byte_i == 8'd0)
    else $error("status result carries data");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_DATA |-> last_i)
    else $error("status result not last of its item");

endmodule

bind radix50_text_packer r50p_checker u_r50p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .status_i    (out_o.status),
  .last_i      (out_o.last)
);

`default_nettype wire
